// ----- rtl/core/bam_pkg.sv -----
// Shared codes, field widths and types of the bitmap allocation map.
`default_nettype none
package bam_pkg;

    // Request and result field widths
    localparam int FUNC_W  = 3;
    localparam int FIRST_W = 10;
    localparam int END_W   = 11;
    localparam int LEN_W   = 11;
    localparam int BIU_W   = 11;
    localparam int START_W = 10;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_SET_BIT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLR_BIT   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST_BIT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET_RANGE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLR_RANGE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_FIND_RUN  = 3'd5;

    // Bit position and whole-byte masks for a map byte
    localparam logic [2:0] BIT_POS_MASK = 3'h7;
    localparam logic [7:0] BYTE_MASK    = 8'hff;

    // Byte unit status back to the sequencer
    typedef struct packed {
        logic       hit;
        logic [7:0] new_byte;
    } bam_byte_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/bam_mem.sv -----
// Map storage: one byte per entry, one write port, one registered read port.
`default_nettype none
module bam_mem
    import bam_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data & BYTE_MASK;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bam_byte_unit.sv -----
// Shared byte unit: range masking and free-run counting over one map byte.
`default_nettype none
module bam_byte_unit
    import bam_pkg::*;
#(
    parameter int CW = 12
) (
    input  wire logic [7:0]    byte_in,
    input  wire logic [CW-1:0] base,
    input  wire logic [CW-1:0] lo,
    input  wire logic [CW-1:0] hi,
    input  wire logic          set_val,
    input  wire logic [CW-1:0] run_in,
    input  wire logic [CW-1:0] run_len,
    input  wire logic [CW-1:0] limit,
    output bam_byte_res_t      res,
    output logic [CW-1:0]      run_out,
    output logic [CW-1:0]      hit_start
);

    logic [CW-1:0] idx      [8];
    logic [CW-1:0] run_at   [8];
    logic          hit_at   [8];
    logic          any_set  [8];
    logic [2:0]    last_set [8];
    logic          hit_any;
    logic [7:0]    byte_out;

    // Per-bit index, run length ending at that bit and hit flag
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            idx[j]      = base + CW'(j);
            any_set[j]  = 1'b0;
            last_set[j] = 3'd0;
            for (int k = 0; k <= j; k++)
            begin
                if (byte_in[k])
                begin
                    any_set[j]  = 1'b1;
                    last_set[j] = 3'(k);
                end
            end
            if (any_set[j])
            begin
                run_at[j] = CW'(3'(j) - last_set[j]);
            end
            else
            begin
                run_at[j] = run_in + CW'(j + 1);
            end
            hit_at[j] = (idx[j] < limit) && (run_at[j] == run_len);
        end
    end

    // New byte for range writes
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            if ((idx[j] >= lo) && (idx[j] < hi))
            begin
                byte_out[j] = set_val;
            end
            else
            begin
                byte_out[j] = byte_in[j];
            end
        end
    end

    // Lowest hit wins
    always_comb
    begin
        hit_any   = 1'b0;
        hit_start = '0;
        for (int j = 7; j >= 0; j--)
        begin
            if (hit_at[j])
            begin
                hit_any   = 1'b1;
                hit_start = idx[j] + CW'(1) - run_len;
            end
        end
    end

    assign res = '{hit: hit_any, new_byte: byte_out};

    // Run carried into the next byte
    always_comb
    begin
        if (any_set[7])
        begin
            run_out = CW'(3'd7 - last_set[7]);
        end
        else
        begin
            run_out = run_in + CW'(8);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bam_ctrl.sv -----
// Sequencer: clearing pass, byte walk over the map and result register.
`default_nettype none
module bam_ctrl
    import bam_pkg::*;
#(
    parameter int MAP_BITS  = 1024,
    parameter int MAP_BYTES = 128,
    parameter int AW        = 7,
    parameter int CW        = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request transfer
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [FIRST_W-1:0] first_bit,
    input  wire logic [END_W-1:0]   end_bit,
    input  wire logic [LEN_W-1:0]   run_length,
    input  wire logic [BIU_W-1:0]   bits_in_use,
    // result transfer
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    bit_value,
    output logic                    found,
    output logic [START_W-1:0]      run_start,
    // memory
    output logic                    wr_en,
    output logic [AW-1:0]           wr_addr,
    output logic [7:0]              wr_data,
    output logic                    rd_en,
    output logic [AW-1:0]           rd_addr,
    input  wire logic [7:0]         rd_data,
    // byte unit
    output logic [CW-1:0]           bu_base,
    output logic [CW-1:0]           bu_lo,
    output logic [CW-1:0]           bu_hi,
    output logic                    bu_val,
    output logic [CW-1:0]           bu_run_in,
    output logic [CW-1:0]           bu_len,
    output logic [CW-1:0]           bu_limit,
    input  wire bam_byte_res_t      bu_res,
    input  wire logic [CW-1:0]      bu_run_out,
    input  wire logic [CW-1:0]      bu_start
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [1:0] MODE_RANGE = 2'd0;
    localparam logic [1:0] MODE_TEST  = 2'd1;
    localparam logic [1:0] MODE_FIND  = 2'd2;

    localparam logic [CW-1:0] MAP_LIM  = CW'(MAP_BITS);
    localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);

    logic [1:0]         state_reg, state_next;
    logic [1:0]         mode_reg, mode_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      last_reg, last_next;
    logic               issue_reg, issue_next;
    logic               dv_reg, dv_next;
    logic [AW-1:0]      dq_addr_reg, dq_addr_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic               val_reg, val_next;
    logic [CW-1:0]      len_reg, len_next;
    logic [CW-1:0]      limit_reg, limit_next;
    logic [2:0]         tpos_reg, tpos_next;
    logic [CW-1:0]      run_reg, run_next;
    logic               res_bit_reg, res_bit_next;
    logic               res_found_reg, res_found_next;
    logic [START_W-1:0] res_start_reg, res_start_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_bit_reg, out_bit_next;
    logic               out_found_reg, out_found_next;
    logic [START_W-1:0] out_start_reg, out_start_next;

    logic [CW-1:0] first_x, end_x, len_x, biu_x;
    logic [CW-1:0] sb_hi, rg_hi, lim;

    // Request decode helpers
    always_comb
    begin
        first_x = CW'(first_bit);
        end_x   = CW'(end_bit);
        len_x   = CW'(run_length);
        biu_x   = CW'(bits_in_use);
        sb_hi   = ((first_x + CW'(1)) > MAP_LIM) ? MAP_LIM : (first_x + CW'(1));
        rg_hi   = (end_x > MAP_LIM) ? MAP_LIM : end_x;
        lim     = (biu_x > MAP_LIM) ? MAP_LIM : biu_x;
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        dv_next        = 1'b0;
        dq_addr_next   = dq_addr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        val_next       = val_reg;
        len_next       = len_reg;
        limit_next     = limit_reg;
        tpos_next      = tpos_reg;
        run_next       = run_reg;
        res_bit_next   = res_bit_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;
        wr_en          = 1'b0;
        wr_addr        = dq_addr_reg;
        wr_data        = bu_res.new_byte;
        rd_en          = 1'b0;
        in_ready       = (state_reg == ST_IDLE);

        // result register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = addr_reg;
                wr_data   = 8'h00;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_BYTE)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_bit_next   = 1'b0;
                    res_found_next = 1'b0;
                    res_start_next = '0;
                    run_next       = '0;
                    lo_next        = first_x;
                    tpos_next      = first_bit[2:0] & BIT_POS_MASK;
                    len_next       = len_x;
                    limit_next     = lim;
                    state_next     = ST_DONE;
                    case (func)
                        FUNC_SET_BIT, FUNC_CLR_BIT:
                        begin
                            mode_next = MODE_RANGE;
                            hi_next   = sb_hi;
                            val_next  = (func == FUNC_SET_BIT);
                            addr_next = first_x[AW+2:3];
                            last_next = first_x[AW+2:3];
                            if (first_x < sb_hi)
                            begin
                                issue_next = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        FUNC_SET_RANGE, FUNC_CLR_RANGE:
                        begin
                            mode_next = MODE_RANGE;
                            hi_next   = rg_hi;
                            val_next  = (func == FUNC_SET_RANGE);
                            addr_next = first_x[AW+2:3];
                            last_next = AW'((rg_hi - CW'(1)) >> 3);
                            if (first_x < rg_hi)
                            begin
                                issue_next = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        FUNC_TEST_BIT:
                        begin
                            mode_next = MODE_TEST;
                            addr_next = first_x[AW+2:3];
                            last_next = first_x[AW+2:3];
                            if (first_x < MAP_LIM)
                            begin
                                issue_next = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        FUNC_FIND_RUN:
                        begin
                            mode_next = MODE_FIND;
                            addr_next = '0;
                            last_next = AW'((lim - CW'(1)) >> 3);
                            if (len_x == '0)
                            begin
                                res_found_next = 1'b1;
                            end
                            else if (len_x <= lim)
                            begin
                                issue_next = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            mode_next = MODE_RANGE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // issue one byte read per cycle
                if (issue_reg)
                begin
                    rd_en        = 1'b1;
                    addr_next    = addr_reg + AW'(1);
                    issue_next   = (addr_reg != last_reg);
                    dv_next      = 1'b1;
                    dq_addr_next = addr_reg;
                end
                // consume the byte read last cycle
                if (dv_reg)
                begin
                    case (mode_reg)
                        MODE_RANGE:
                        begin
                            wr_en = 1'b1;
                            if (dq_addr_reg == last_reg)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        MODE_TEST:
                        begin
                            res_bit_next = rd_data[tpos_reg];
                            state_next   = ST_DONE;
                        end
                        MODE_FIND:
                        begin
                            run_next = bu_run_out;
                            if (bu_res.hit)
                            begin
                                res_found_next = 1'b1;
                                res_start_next = bu_start[START_W-1:0];
                                issue_next     = 1'b0;
                                dv_next        = 1'b0;
                                state_next     = ST_DONE;
                            end
                            else if (dq_addr_reg == last_reg)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = res_bit_reg;
                    out_found_next = res_found_reg;
                    out_start_next = res_start_reg;
                    issue_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            issue_reg     <= issue_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        last_reg      <= last_next;
        dq_addr_reg   <= dq_addr_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        val_reg       <= val_next;
        len_reg       <= len_next;
        limit_reg     <= limit_next;
        tpos_reg      <= tpos_next;
        run_reg       <= run_next;
        res_bit_reg   <= res_bit_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        out_bit_reg   <= out_bit_next;
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
    end

    assign rd_addr   = addr_reg;
    assign out_valid = out_valid_reg;
    assign bit_value = out_bit_reg;
    assign found     = out_found_reg;
    assign run_start = out_start_reg;
    assign bu_base   = CW'({dq_addr_reg, 3'b000});
    assign bu_lo     = lo_reg;
    assign bu_hi     = hi_reg;
    assign bu_val    = val_reg;
    assign bu_run_in = run_reg;
    assign bu_len    = len_reg;
    assign bu_limit  = limit_reg;

endmodule
`default_nettype wire

// ----- rtl/core/bitmap_allocation_map.sv -----
// Top level of the bitmap allocation map with first-fit run search.
//
// Channel  Dir  Handshake           Payload
// s_axis   in   s_tvalid/s_tready   tdata: first_bit, end_bit, run_length; tuser: func
// m_axis   out  m_tvalid/m_tready   tdata: bit_value, run_start; tuser: found
// cfg      in   cfg_wr_en           cfg_wr_data: bits_in_use
//
// Cycles: bytes walked + 3 per request, one byte per cycle through the single
// read port and the shared byte unit; 131 for a full run search at 1024 bits,
// 2 when no byte is walked (empty range, zero or too long run, unused code).
// Reset: a clearing pass zeroes all MAP_BITS/8 bytes (128 cycles at 1024 bits)
// before the first request is taken; bits_in_use resets to 1024.
// Stalls: a waiting result holds its register; one more request may be taken.
`default_nettype none
module bitmap_allocation_map
    import bam_pkg::*;
#(
    parameter int MAP_BITS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request: [9:0] first_bit, [20:10] end_bit, [31:21] run_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    // request: [2:0] func
    input  wire logic [2:0]  s_tuser,
    // result: [0] bit_value, [10:1] run_start, [15:11] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    // result: [0] found
    output logic             m_tuser,
    // configuration: bits_in_use
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data
);

    localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
    localparam int AW        = $clog2(MAP_BYTES);
    localparam int IW        = $clog2(MAP_BITS + 1);
    localparam int CW        = ((IW > 11) ? IW : 11) + 1;

    logic [BIU_W-1:0]   bits_in_use_reg;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [7:0]         wr_data, rd_data;
    logic [CW-1:0]      bu_base, bu_lo, bu_hi, bu_run_in, bu_len, bu_limit;
    logic [CW-1:0]      bu_run_out, bu_start;
    logic               bu_val;
    bam_byte_res_t      bu_res;
    logic               bit_value, found;
    logic [START_W-1:0] run_start;

    // Search limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= 11'd1024;
        end
        else if (cfg_wr_en)
        begin
            bits_in_use_reg <= cfg_wr_data;
        end
    end

    bam_ctrl #(
        .MAP_BITS  (MAP_BITS),
        .MAP_BYTES (MAP_BYTES),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .func        (s_tuser),
        .first_bit   (s_tdata[9:0]),
        .end_bit     (s_tdata[20:10]),
        .run_length  (s_tdata[31:21]),
        .bits_in_use (bits_in_use_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .bit_value   (bit_value),
        .found       (found),
        .run_start   (run_start),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .bu_base     (bu_base),
        .bu_lo       (bu_lo),
        .bu_hi       (bu_hi),
        .bu_val      (bu_val),
        .bu_run_in   (bu_run_in),
        .bu_len      (bu_len),
        .bu_limit    (bu_limit),
        .bu_res      (bu_res),
        .bu_run_out  (bu_run_out),
        .bu_start    (bu_start)
    );

    bam_byte_unit #(
        .CW (CW)
    ) u_byte_unit (
        .byte_in   (rd_data),
        .base      (bu_base),
        .lo        (bu_lo),
        .hi        (bu_hi),
        .set_val   (bu_val),
        .run_in    (bu_run_in),
        .run_len   (bu_len),
        .limit     (bu_limit),
        .res       (bu_res),
        .run_out   (bu_run_out),
        .hit_start (bu_start)
    );

    bam_mem #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result packing
    assign m_tdata = {5'b00000, run_start, bit_value};
    assign m_tuser = found;

endmodule
`default_nettype wire

// ----- bench/tb_bitmap_allocation_map.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap allocation map: directed table, then random phases.
module tb_bitmap_allocation_map
    import bam_pkg::*;
();

    localparam int MAP_BITS  = 1024;
    localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
    localparam int NUM_ROWS  = 25;
    localparam int NUM_SEGS  = 8;
    localparam int SEG_ITEMS = 175;
    localparam int SETTLE_CYC = 140;

    // Codes the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FIRST_W-1:0] first_bit;
        logic [END_W-1:0]   end_bit;
        logic [LEN_W-1:0]   run_length;
    } alloc_req_t;

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [START_W-1:0] run_start;
    } alloc_res_t;

    typedef struct packed {
        alloc_req_t req;
        logic       typed;
        alloc_res_t res;
    } dir_row_t;

    typedef struct packed {
        logic [FIRST_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } held_block_t;

    // Directed rows; typed results only where obvious
    localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
        // fresh map reads back free
        '{'{FUNC_TEST_BIT,  10'd0,    11'd0,    11'd0},    1'b1, '{1'b0, 1'b0, 10'd0}},
        '{'{FUNC_TEST_BIT,  10'd1023, 11'd0,    11'd0},    1'b1, '{1'b0, 1'b0, 10'd0}},
        // whole map free, zero length, too long
        '{'{FUNC_FIND_RUN,  10'd0,    11'd0,    11'd1024}, 1'b1, '{1'b0, 1'b1, 10'd0}},
        '{'{FUNC_FIND_RUN,  10'd0,    11'd0,    11'd0},    1'b1, '{1'b0, 1'b1, 10'd0}},
        '{'{FUNC_FIND_RUN,  10'd0,    11'd0,    11'd2047}, 1'b1, '{1'b0, 1'b0, 10'd0}},
        // map edges
        '{'{FUNC_SET_BIT,   10'd0,    11'd0,    11'd0},    1'b1, '{1'b0, 1'b0, 10'd0}},
        '{'{FUNC_SET_BIT,   10'd1023, 11'd0,    11'd0},    1'b1, '{1'b0, 1'b0, 10'd0}},
        '{'{FUNC_TEST_BIT,  10'd1023, 11'd0,    11'd0},    1'b1, '{1'b1, 1'b0, 10'd0}},
        '{'{FUNC_FIND_RUN,  10'd0,    11'd0,    11'd1},    1'b0, '0},
        '{'{FUNC_FIND_RUN,  10'd0,    11'd0,    11'd1022}, 1'b0, '0},
        '{'{FUNC_FIND_RUN,  10'd0,    11'd0,    11'd1023}, 1'b0, '0},
        // empty and reversed ranges, end past the map
        '{'{FUNC_SET_RANGE, 10'd5,    11'd5,    11'd0},    1'b0, '0},
        '{'{FUNC_SET_RANGE, 10'd100,  11'd50,   11'd0},    1'b0, '0},
        '{'{FUNC_SET_RANGE, 10'd1000, 11'd2047, 11'd0},    1'b0, '0},
        '{'{FUNC_TEST_BIT,  10'd1000, 11'd0,    11'd0},    1'b0, '0},
        '{'{FUNC_CLR_RANGE, 10'd0,    11'd2047, 11'd0},    1'b0, '0},
        // range across a byte boundary, then a search, a clear and a test around it
        '{'{FUNC_SET_RANGE, 10'd3,    11'd13,   11'd0},    1'b0, '0},
        '{'{FUNC_FIND_RUN,  10'd0,    11'd0,    11'd3},    1'b0, '0},
        '{'{FUNC_CLR_BIT,   10'd7,    11'd0,    11'd0},    1'b0, '0},
        '{'{FUNC_TEST_BIT,  10'd7,    11'd0,    11'd0},    1'b0, '0},
        // unused codes with every field bit high
        '{'{FUNC_RSVD_6,    10'd1023, 11'd2047, 11'd2047}, 1'b1, '{1'b0, 1'b0, 10'd0}},
        '{'{FUNC_RSVD_7,    10'd1023, 11'd2047, 11'd2047}, 1'b1, '{1'b0, 1'b0, 10'd0}},
        // full map: single free bit search fails
        '{'{FUNC_SET_RANGE, 10'd0,    11'd1024, 11'd0},    1'b0, '0},
        '{'{FUNC_FIND_RUN,  10'd0,    11'd0,    11'd1},    1'b0, '0},
        '{'{FUNC_CLR_RANGE, 10'd0,    11'd1024, 11'd0},    1'b0, '0}
    };

    // Per phase: bits in use (-1 random), sender idle and receiver stall percentages
    localparam int SEG_BIU  [NUM_SEGS] = '{1024, 1, 300, 2047, 0, 777, 1024, -1};
    localparam int SEG_SEND [NUM_SEGS] = '{0, 57, 0, 11, 0, 57, 0, 11};
    localparam int SEG_RECV [NUM_SEGS] = '{0, 0, 57, 11, 0, 0, 57, 11};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;

    // Predictor state and bookkeeping
    logic [7:0]       map_bytes [MAP_BYTES];
    logic [BIU_W-1:0] search_limit;
    alloc_res_t       pending_results [$];
    held_block_t      held_blocks [$];
    int               err_cnt;
    int               send_idle_pct;
    int               recv_stall_pct;

    bitmap_allocation_map #(
        .MAP_BITS (MAP_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic map_bit(int unsigned idx);
        if (idx >= MAP_BITS)
            return 1'b0;
        return map_bytes[idx >> 3][idx & BIT_POS_MASK];
    endfunction

    function automatic void write_map_bit(int unsigned idx, logic val);
        if (idx < MAP_BITS)
            map_bytes[idx >> 3][idx & BIT_POS_MASK] = val;
    endfunction

    // Applies one request to the predicted map and returns its result
    function automatic alloc_res_t apply_alloc_op(alloc_req_t r);
        alloc_res_t  res;
        int unsigned hi;
        int unsigned limit;
        int unsigned run;
        int unsigned idx;
        res = '0;
        case (r.func)
            FUNC_SET_BIT:   write_map_bit(r.first_bit, 1'b1);
            FUNC_CLR_BIT:   write_map_bit(r.first_bit, 1'b0);
            FUNC_TEST_BIT:  res.bit_value = map_bit(r.first_bit);
            FUNC_SET_RANGE, FUNC_CLR_RANGE:
            begin
                hi = (r.end_bit > MAP_BITS) ? MAP_BITS : r.end_bit;
                for (idx = r.first_bit; idx < hi; idx++)
                    write_map_bit(idx, r.func == FUNC_SET_RANGE);
            end
            FUNC_FIND_RUN:
            begin
                limit = (search_limit > MAP_BITS) ? MAP_BITS : search_limit;
                if (r.run_length == 0)
                    res.found = 1'b1;
                else if (r.run_length <= limit)
                begin
                    run = 0;
                    for (idx = 0; idx < limit && !res.found; idx++)
                    begin
                        if (map_bit(idx))
                            run = 0;
                        else
                        begin
                            run++;
                            if (run == r.run_length)
                            begin
                                res.found     = 1'b1;
                                res.run_start = START_W'(idx + 1 - r.run_length);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Drive one request until its transfer, then log the expected result
    task automatic send_request(input alloc_req_t r, input logic typed,
                                input alloc_res_t typed_res, output alloc_res_t pred);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.run_length, r.end_bit, r.first_bit};
        s_tuser  <= r.func;
        do
            @(posedge clk);
        while (!s_tready);
        pred = apply_alloc_op(r);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // Drop the request and wait until every expected result is back
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_bits_in_use(input logic [BIU_W-1:0] val);
        @(negedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= val;
        search_limit = val;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
    endtask

    // Random requests: mostly allocate/free traffic around first-fit searches
    task automatic run_random_phase(input int num_items);
        alloc_req_t  r;
        alloc_res_t  res;
        held_block_t blk;
        logic        alloc_next;
        logic [FIRST_W-1:0] alloc_start;
        logic [LEN_W-1:0]   alloc_len;
        int          k;
        int          pick;
        alloc_next  = 1'b0;
        alloc_start = '0;
        alloc_len   = '0;
        for (k = 0; k < num_items; k++)
        begin
            r.first_bit  = FIRST_W'($urandom);
            r.end_bit    = END_W'($urandom);
            r.run_length = LEN_W'($urandom);
            if (alloc_next && $urandom_range(99) < 80)
            begin
                // claim the run just found
                r.func      = FUNC_SET_RANGE;
                r.first_bit = alloc_start;
                r.end_bit   = END_W'(alloc_start) + alloc_len;
                blk.start   = alloc_start;
                blk.len     = alloc_len;
                held_blocks.push_back(blk);
            end
            else if (held_blocks.size() != 0 && $urandom_range(99) < 20)
            begin
                // release a held block
                pick        = $urandom_range(held_blocks.size() - 1);
                blk         = held_blocks[pick];
                held_blocks.delete(pick);
                r.func      = FUNC_CLR_RANGE;
                r.first_bit = blk.start;
                r.end_bit   = END_W'(blk.start) + blk.len;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    r.func = FUNC_SET_BIT;
                else if (pick < 22)
                    r.func = FUNC_CLR_BIT;
                else if (pick < 36)
                    r.func = FUNC_TEST_BIT;
                else if (pick < 54)
                begin
                    r.func = (pick < 46) ? FUNC_SET_RANGE : FUNC_CLR_RANGE;
                    // short ranges mostly; now and then any end at all
                    if ($urandom_range(9) != 0)
                        r.end_bit = END_W'(r.first_bit) + END_W'($urandom_range(40));
                end
                else if (pick < 96)
                begin
                    r.func = FUNC_FIND_RUN;
                    if ($urandom_range(9) != 0)
                        r.run_length = LEN_W'($urandom_range(24));
                end
                else
                    r.func = $urandom_range(1) ? FUNC_RSVD_7 : FUNC_RSVD_6;
            end
            send_request(r, 1'b0, '0, res);
            alloc_next  = (r.func == FUNC_FIND_RUN) && res.found && (r.run_length != 0);
            alloc_start = res.run_start;
            alloc_len   = r.run_length;
        end
    endtask

    // Receiver stalls
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checking
    always @(posedge clk)
    begin
        alloc_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.bit_value)
                begin
                    $display("%0t: bit_value expected %0d actual %0d",
                             $time, want.bit_value, m_tdata[0]);
                    err_cnt++;
                end
                if (m_tuser !== want.found)
                begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[10:1] !== want.run_start)
                begin
                    $display("%0t: run_start expected %0d actual %0d",
                             $time, want.run_start, m_tdata[10:1]);
                    err_cnt++;
                end
                if (m_tdata[15:11] !== 5'd0)
                begin
                    $display("%0t: tdata padding expected 0 actual %h",
                             $time, m_tdata[15:11]);
                    err_cnt++;
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        alloc_res_t res;
        int         n;
        int         seg;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        err_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        search_limit   = 11'd1024;
        for (n = 0; n < MAP_BYTES; n++)
            map_bytes[n] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (n = 0; n < NUM_ROWS; n++)
            send_request(DIR_ROWS[n].req, DIR_ROWS[n].typed, DIR_ROWS[n].res, res);
        drain();

        // random phases, each with its own limit and idling pattern
        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            write_bits_in_use((SEG_BIU[seg] < 0) ? BIU_W'($urandom_range(1024))
                                                 : BIU_W'(SEG_BIU[seg]));
            send_idle_pct  = SEG_SEND[seg];
            recv_stall_pct = SEG_RECV[seg];
            run_random_phase(SEG_ITEMS);
            drain();
        end

        repeat (SETTLE_CYC) @(posedge clk);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
